FILE: rtl/core/bcds_pkg.sv
// Shared types and constants for the backface cull and depth bucket sort block.
// Holds the command and result item layouts, the state types and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package bcds_pkg;

	localparam int COORD_W   = 24;
	localparam int ID_W      = 10;
	localparam int BKT_W     = 16;
	localparam int OUT_BKT_W = 12;
	localparam int OP_W      = 25;
	localparam int PROD_W    = 2 * OP_W;
	localparam int M_W       = 49;
	localparam int ACC_W     = PROD_W + 24;
	localparam int SUM_W     = 26;
	localparam int DIV_X_W   = 18;
	localparam int LIM_W     = 17;

	// floor(2^20 / 5): quotient estimate is low by at most one
	localparam logic [17:0] RECIP_5 = 18'd209715;
	localparam int          RECIP_SHIFT = 20;

	// Multiplier schedule, one operand pair per step
	localparam logic [3:0] MUL_BYCZ  = 4'd0;
	localparam logic [3:0] MUL_BZCY  = 4'd1;
	localparam logic [3:0] MUL_BXCZ  = 4'd2;
	localparam logic [3:0] MUL_BZCX  = 4'd3;
	localparam logic [3:0] MUL_BYCX  = 4'd4;
	localparam logic [3:0] MUL_BXCY  = 4'd5;
	localparam logic [3:0] MUL_DIV   = 4'd6;
	localparam logic [3:0] MUL_AX_H  = 4'd7;
	localparam logic [3:0] MUL_AX_L  = 4'd8;
	localparam logic [3:0] MUL_AY_H  = 4'd9;
	localparam logic [3:0] MUL_AY_L  = 4'd10;
	localparam logic [3:0] MUL_AZ_H  = 4'd11;
	localparam logic [3:0] MUL_AZ_L  = 4'd12;
	localparam logic [3:0] STEP_LAST = 4'd13;

	typedef logic [ID_W:0] link_t;
	localparam link_t NO_FACE = {1'b1, {ID_W{1'b0}}};

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_FACE = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef struct packed {
		logic             drain;
		logic [ID_W-1:0]  id;
		logic             visible;
		logic             dropped;
		logic [BKT_W-1:0] bkt;
	} cmd_t;

	typedef struct packed {
		kind_t                kind;
		logic [ID_W-1:0]      id;
		logic                 visible;
		logic [OUT_BKT_W-1:0] bkt;
		logic                 dropped;
	} res_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_INSERT,
		B_DR_CHK,
		B_DR_LINK,
		B_DR_HEAD,
		B_RESP
	} back_state_t;

	function automatic logic signed [OP_W-1:0] sext_op(input logic signed [COORD_W-1:0] v);
		return OP_W'(v);
	endfunction

endpackage

FILE: rtl/core/bcds_fifo.sv
// Small synchronous queue used between the front and back and on the result side.
// Depth must be a power of two. No dependencies.
`timescale 1ns / 1ps

module bcds_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

FILE: rtl/core/bcds_front.sv
// Front end: accepts items, runs the triple-product backface test and the depth
// bucket divide on one shared 25x25 multiplier. Depends on bcds_pkg.
`timescale 1ns / 1ps

module bcds_front import bcds_pkg::*; #(
	parameter int BUCKETS   = 4096,
	parameter int MAX_FACES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      hold,
	input  logic                      command,
	input  logic [ID_W-1:0]           face_id,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] az,
	input  logic signed [COORD_W-1:0] bx_coord,
	input  logic signed [COORD_W-1:0] by_coord,
	input  logic signed [COORD_W-1:0] bz_coord,
	input  logic signed [COORD_W-1:0] cx_coord,
	input  logic signed [COORD_W-1:0] cy_coord,
	input  logic signed [COORD_W-1:0] cz_coord,
	output logic                      cmd_push,
	output cmd_t                      cmd_out,
	input  logic                      cmd_full
);

	front_state_t state_q, state_d;
	logic [3:0]   step_q;
	logic         drain_q;
	logic [ID_W-1:0] id_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [SUM_W-1:0]   s_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [M_W-1:0]     m1_q, m2_q, m3_q;
	logic [BKT_W-1:0]          q_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [OP_W-1:0] op_a, op_b;
	logic [DIV_X_W-1:0]     div_x;
	logic [DIV_X_W:0]       rem;
	logic                   accept;
	logic                   vis;
	logic                   over;
	logic [BKT_W-1:0]       bkt;

	assign accept = push && !full;
	assign div_x  = s_q[SUM_W-1] ? '0 : s_q[SUM_W-1:8];
	assign rem    = (DIV_X_W+1)'(div_x) - (DIV_X_W+1)'({q_q, 2'b00}) - (DIV_X_W+1)'(q_q);

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			MUL_BYCZ: begin op_a = sext_op(by_q); op_b = sext_op(cz_q); end
			MUL_BZCY: begin op_a = sext_op(bz_q); op_b = sext_op(cy_q); end
			MUL_BXCZ: begin op_a = sext_op(bx_q); op_b = sext_op(cz_q); end
			MUL_BZCX: begin op_a = sext_op(bz_q); op_b = sext_op(cx_q); end
			MUL_BYCX: begin op_a = sext_op(by_q); op_b = sext_op(cx_q); end
			MUL_BXCY: begin op_a = sext_op(bx_q); op_b = sext_op(cy_q); end
			MUL_DIV: begin op_a = OP_W'(div_x); op_b = OP_W'(RECIP_5); end
			MUL_AX_H: begin op_a = sext_op(ax_q); op_b = m1_q[M_W-1:24]; end
			MUL_AX_L: begin op_a = sext_op(ax_q); op_b = {1'b0, m1_q[23:0]}; end
			MUL_AY_H: begin op_a = -sext_op(ay_q); op_b = m2_q[M_W-1:24]; end
			MUL_AY_L: begin op_a = -sext_op(ay_q); op_b = {1'b0, m2_q[23:0]}; end
			MUL_AZ_H: begin op_a = -sext_op(az_q); op_b = m3_q[M_W-1:24]; end
			MUL_AZ_L: begin op_a = -sext_op(az_q); op_b = {1'b0, m3_q[23:0]}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = command ? F_PUSH : F_CALC;
			F_CALC: if (step_q == STEP_LAST) state_d = F_PUSH;
			F_PUSH: if (!cmd_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		vis  = acc_q[ACC_W-1] && !drain_q;
		bkt  = s_q[SUM_W-1] ? '0 : q_q;
		over = ({1'b0, bkt} >= LIM_W'(BUCKETS)) || (LIM_W'(id_q) >= LIM_W'(MAX_FACES));
		full     = (state_q != F_IDLE) || hold;
		cmd_push = (state_q == F_PUSH) && !cmd_full;
		cmd_out.drain   = drain_q;
		cmd_out.id      = id_q;
		cmd_out.visible = vis;
		cmd_out.dropped = vis && over;
		cmd_out.bkt     = (vis && !over) ? bkt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) step_q <= '0;
			else if (state_q == F_CALC) step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drain_q <= command;
			id_q    <= face_id;
			ax_q <= ax;       ay_q <= ay;       az_q <= az;
			bx_q <= bx_coord; by_q <= by_coord; bz_q <= bz_coord;
			cx_q <= cx_coord; cy_q <= cy_coord; cz_q <= cz_coord;
			s_q  <= SUM_W'(az) + SUM_W'(bz_coord) + SUM_W'(cz_coord);
			acc_q <= '0;
		end
		if (state_q == F_CALC) begin
			prod_q <= op_a * op_b;
			// prod_q holds the product issued at the previous step
			case (step_q)
				MUL_BZCY: m1_q <= M_W'(prod_q);
				MUL_BXCZ: m1_q <= m1_q - M_W'(prod_q);
				MUL_BZCX: m2_q <= M_W'(prod_q);
				MUL_BYCX: m2_q <= m2_q - M_W'(prod_q);
				MUL_BXCY: m3_q <= M_W'(prod_q);
				MUL_DIV: m3_q <= m3_q - M_W'(prod_q);
				MUL_AX_H: q_q <= prod_q[RECIP_SHIFT+BKT_W-1:RECIP_SHIFT];
				MUL_AX_L: begin
					acc_q <= {prod_q, 24'd0};
					if (rem >= (DIV_X_W+1)'(5)) q_q <= q_q + 1'b1;
				end
				MUL_AY_H, MUL_AZ_H, STEP_LAST: acc_q <= acc_q + ACC_W'(prod_q);
				MUL_AY_L, MUL_AZ_L: acc_q <= acc_q + {prod_q, 24'd0};
				default: acc_q <= acc_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/bcds_back.sv
// Back end: keeps the per-bucket face lists in a head table and a link table,
// inserts classified faces and walks the lists on drain. Depends on bcds_pkg.
`timescale 1ns / 1ps

module bcds_back import bcds_pkg::*; #(
	parameter int BUCKETS   = 4096,
	parameter int MAX_FACES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd_in,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res_out,
	output logic clearing
);

	localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int LW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

	back_state_t state_q, state_d;
	logic [HW-1:0] clr_q;
	logic [HW-1:0] db_q, db_d;
	link_t         cur_q, cur_d;
	cmd_t          cmd_q;
	res_t          res_q, res_d;
	link_t         head_rd_q, link_rd_q;
	link_t         head_mem [BUCKETS];
	link_t         link_mem [MAX_FACES];

	logic          head_we, head_re, link_we, link_re;
	logic [HW-1:0] head_waddr, head_raddr;
	link_t         head_wdata;
	logic [LW-1:0] link_waddr, link_raddr;
	logic          db_we, cur_we, res_we;
	logic          clr_done;
	logic          in_store;

	assign clr_done = (clr_q == HW'(BUCKETS - 1));
	assign in_store = cmd_in.visible && !cmd_in.dropped;
	assign clearing = (state_q == B_CLEAR);
	assign res_out  = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_done) state_d = B_IDLE;
			B_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_in.drain) state_d = B_DR_CHK;
					else if (in_store) state_d = B_INSERT;
					else state_d = B_RESP;
				end
			end
			B_INSERT: state_d = B_RESP;
			B_DR_CHK: state_d = cur_q[ID_W] ? B_DR_HEAD : B_DR_LINK;
			B_DR_LINK: state_d = B_RESP;
			B_DR_HEAD: begin
				if (!head_rd_q[ID_W]) state_d = B_DR_CHK;
				else if (db_q == '0) state_d = B_RESP;
			end
			B_RESP: if (!res_full) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		head_we    = 1'b0;
		head_re    = 1'b0;
		link_we    = 1'b0;
		link_re    = 1'b0;
		head_waddr = clr_q;
		head_wdata = NO_FACE;
		head_raddr = db_q;
		link_waddr = LW'(cmd_q.id);
		link_raddr = LW'(cur_q[ID_W-1:0]);
		db_we      = 1'b0;
		db_d       = db_q;
		cur_we     = 1'b0;
		cur_d      = cur_q;
		res_we     = 1'b0;
		res_d      = res_q;
		unique case (state_q)
			B_CLEAR: head_we = 1'b1;
			B_IDLE: begin
				cmd_pop = !cmd_empty;
				if (!cmd_empty && !cmd_in.drain) begin
					if (in_store) begin
						head_re    = 1'b1;
						head_raddr = HW'(cmd_in.bkt);
					end else begin
						res_we = 1'b1;
						res_d  = '{kind: KIND_ACK, id: cmd_in.id, visible: cmd_in.visible,
							bkt: '0, dropped: cmd_in.dropped};
					end
				end
			end
			B_INSERT: begin
				// push at the head of the bucket list
				link_we    = 1'b1;
				head_we    = 1'b1;
				head_waddr = HW'(cmd_q.bkt);
				head_wdata = {1'b0, cmd_q.id};
				res_we     = 1'b1;
				res_d      = '{kind: KIND_ACK, id: cmd_q.id, visible: 1'b1,
					bkt: OUT_BKT_W'(cmd_q.bkt), dropped: 1'b0};
			end
			B_DR_CHK: begin
				if (!cur_q[ID_W]) link_re = 1'b1;
				else head_re = 1'b1;
			end
			B_DR_LINK: begin
				cur_we = 1'b1;
				cur_d  = link_rd_q;
				res_we = 1'b1;
				res_d  = '{kind: KIND_FACE, id: cur_q[ID_W-1:0], visible: 1'b1,
					bkt: OUT_BKT_W'(db_q), dropped: 1'b0};
			end
			B_DR_HEAD: begin
				if (!head_rd_q[ID_W]) begin
					// take the whole list and empty the bucket
					head_we    = 1'b1;
					head_waddr = db_q;
					cur_we     = 1'b1;
					cur_d      = head_rd_q;
				end else if (db_q == '0) begin
					db_we  = 1'b1;
					db_d   = HW'(BUCKETS - 1);
					res_we = 1'b1;
					res_d  = '{kind: KIND_DONE, id: '0, visible: 1'b0, bkt: '0, dropped: 1'b0};
				end else begin
					head_re    = 1'b1;
					head_raddr = db_q - 1'b1;
					db_we      = 1'b1;
					db_d       = db_q - 1'b1;
				end
			end
			B_RESP: res_push = !res_full;
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			db_q    <= HW'(BUCKETS - 1);
			cur_q   <= NO_FACE;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (db_we) db_q <= db_d;
			if (cur_we) cur_q <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd_in;
		if (res_we) res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		if (head_re) head_rd_q <= head_mem[head_raddr];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_waddr] <= head_rd_q;
		if (link_re) link_rd_q <= link_mem[link_raddr];
	end

endmodule

FILE: rtl/core/backface_cull_depth_bucket_sort.sv
// Backface cull and depth bucket sort. A submit item runs in the front end on the
// 14-step schedule of its single shared 25x25 multiplier; the back end then answers
// a face that is not stored, and inserts and answers one that is. A drain item
// yields the next stored face, or a done result once the scan has passed bucket 0;
// empty buckets are skipped as the bucket head table is read one entry a cycle.
// After reset a clearing pass empties the head table and full stays high until it
// ends. A two-entry queue sits between the front and back ends, and a two-entry
// result queue feeds the result ports.
`timescale 1ns / 1ps

module backface_cull_depth_bucket_sort import bcds_pkg::*; #(
	parameter int BUCKETS   = 4096,
	parameter int MAX_FACES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        command,
	input  logic [ID_W-1:0]             face_id,
	input  logic signed [COORD_W-1:0]   ax,
	input  logic signed [COORD_W-1:0]   ay,
	input  logic signed [COORD_W-1:0]   az,
	input  logic signed [COORD_W-1:0]   bx_coord,
	input  logic signed [COORD_W-1:0]   by_coord,
	input  logic signed [COORD_W-1:0]   bz_coord,
	input  logic signed [COORD_W-1:0]   cx_coord,
	input  logic signed [COORD_W-1:0]   cy_coord,
	input  logic signed [COORD_W-1:0]   cz_coord,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  result_kind,
	output logic [ID_W-1:0]             out_face_id,
	output logic                        visible,
	output logic [OUT_BKT_W-1:0]        bucket,
	output logic                        dropped
);

	logic clearing;
	logic mid_push, mid_full, mid_pop, mid_empty;
	cmd_t mid_wr, mid_rd;
	logic res_push, res_full;
	res_t res_wr, res_rd;

	bcds_front #(
		.BUCKETS  (BUCKETS),
		.MAX_FACES(MAX_FACES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.hold    (clearing),
		.command (command),
		.face_id (face_id),
		.ax      (ax),
		.ay      (ay),
		.az      (az),
		.bx_coord(bx_coord),
		.by_coord(by_coord),
		.bz_coord(bz_coord),
		.cx_coord(cx_coord),
		.cy_coord(cy_coord),
		.cz_coord(cz_coord),
		.cmd_push(mid_push),
		.cmd_out (mid_wr),
		.cmd_full(mid_full)
	);

	bcds_fifo #(
		.W    ($bits(cmd_t)),
		.DEPTH(2)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wr),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rd),
		.empty (mid_empty)
	);

	bcds_back #(
		.BUCKETS  (BUCKETS),
		.MAX_FACES(MAX_FACES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(mid_empty),
		.cmd_in   (mid_rd),
		.cmd_pop  (mid_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_out  (res_wr),
		.clearing (clearing)
	);

	bcds_fifo #(
		.W    ($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_wr),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rd),
		.empty (empty)
	);

	assign result_kind = res_rd.kind;
	assign out_face_id = res_rd.id;
	assign visible     = res_rd.visible;
	assign bucket      = res_rd.bkt;
	assign dropped     = res_rd.dropped;

`ifndef SYNTHESIS
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid_push && mid_full)) else $error("command queue pushed while full");

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full)) else $error("result queue pushed while full");

	a_hold_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full) else $error("input open during head table clear");

	a_done_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res_rd.kind == KIND_DONE) |-> (out_face_id == '0 && bucket == '0))
		else $error("drain done result carries a face");
`endif

endmodule

FILE: dv/bcds_checker.sv
// Checker for the backface cull and depth bucket sort block: watches both queue sides,
// predicts every result from its own copy of the bucket lists and compares them.
// Depends on bcds_pkg for widths and the result kind codes.
`timescale 1ns / 1ps

module bcds_checker import bcds_pkg::*; #(
	parameter int BUCKETS   = 4096,
	parameter int MAX_FACES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      full,
	input  logic                      command,
	input  logic [ID_W-1:0]           face_id,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] az,
	input  logic signed [COORD_W-1:0] bx_coord,
	input  logic signed [COORD_W-1:0] by_coord,
	input  logic signed [COORD_W-1:0] bz_coord,
	input  logic signed [COORD_W-1:0] cx_coord,
	input  logic signed [COORD_W-1:0] cy_coord,
	input  logic signed [COORD_W-1:0] cz_coord,
	input  logic                      empty,
	input  logic                      pop,
	input  logic [1:0]                result_kind,
	input  logic [ID_W-1:0]           out_face_id,
	input  logic                      visible,
	input  logic [OUT_BKT_W-1:0]      bucket,
	input  logic                      dropped,
	output int                        fails,
	output int                        pending,
	output int                        results_seen,
	output int                        faces_drained,
	output int                        faces_dropped,
	output int                        faces_culled,
	output int                        drains_done
);

	typedef struct {
		kind_t                kind;
		logic [ID_W-1:0]      id;
		logic                 vis;
		logic [OUT_BKT_W-1:0] bkt;
		logic                 drop;
	} face_result_t;

	face_result_t sorted_results[$];
	int           head_of[BUCKETS];
	int           link_of[MAX_FACES];
	int           scan_bkt;
	int           cursor;

	assign pending = sorted_results.size();

	task automatic cull_and_bin();
		face_result_t           r;
		longint                 m1, m2, m3, depth_sum, bkt;
		logic signed [127:0]    wa, wy, wz, w1, w2, w3, det;
		m1 = longint'(by_coord) * longint'(cz_coord) - longint'(bz_coord) * longint'(cy_coord);
		m2 = longint'(bx_coord) * longint'(cz_coord) - longint'(bz_coord) * longint'(cx_coord);
		m3 = longint'(by_coord) * longint'(cx_coord) - longint'(bx_coord) * longint'(cy_coord);
		wa = ax;
		wy = ay;
		wz = az;
		w1 = m1;
		w2 = m2;
		w3 = m3;
		det = wa * w1 - wy * w2 - wz * w3;
		r = '{KIND_ACK, face_id, 1'b0, '0, 1'b0};
		if (det < 0) begin
			r.vis = 1'b1;
			depth_sum = longint'(az) + longint'(bz_coord) + longint'(cz_coord);
			bkt = depth_sum < 0 ? 0 : depth_sum / 1280;
			if (bkt >= BUCKETS || int'(face_id) >= MAX_FACES) begin
				r.drop = 1'b1;
				faces_dropped++;
			end else begin
				link_of[face_id] = head_of[bkt];
				head_of[bkt] = int'(face_id);
				r.bkt = OUT_BKT_W'(bkt);
			end
		end else begin
			faces_culled++;
		end
		sorted_results.push_back(r);
	endtask

	task automatic drain_next();
		face_result_t r;
		bit           got;
		got = 1'b0;
		while (!got) begin
			if (scan_bkt >= BUCKETS)
				scan_bkt = BUCKETS - 1;
			if (cursor >= 0 && cursor < MAX_FACES) begin
				r = '{KIND_FACE, ID_W'(cursor), 1'b1, OUT_BKT_W'(scan_bkt), 1'b0};
				cursor = link_of[cursor];
				got = 1'b1;
			end else begin
				cursor = -1;
				if (head_of[scan_bkt] >= 0) begin
					// take the whole list and empty the bucket
					cursor = head_of[scan_bkt];
					head_of[scan_bkt] = -1;
				end else if (scan_bkt == 0) begin
					scan_bkt = BUCKETS - 1;
					r = '{KIND_DONE, '0, 1'b0, '0, 1'b0};
					got = 1'b1;
				end else begin
					scan_bkt--;
				end
			end
		end
		sorted_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		face_result_t e;
		if (!arst_n) begin
			foreach (head_of[i])
				head_of[i] = -1;
			foreach (link_of[i])
				link_of[i] = -1;
			scan_bkt = BUCKETS - 1;
			cursor = -1;
			sorted_results.delete();
			fails = 0;
			results_seen = 0;
			faces_drained = 0;
			faces_dropped = 0;
			faces_culled = 0;
			drains_done = 0;
		end else begin
			// compare first so an item accepted on this edge never meets its own result
			if (pop && !empty) begin
				results_seen++;
				if (sorted_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t unexpected result kind=%0d id=%0d", $realtime,
							result_kind, out_face_id);
				end else begin
					e = sorted_results.pop_front();
					if (result_kind != e.kind || out_face_id != e.id || visible != e.vis
							|| bucket != e.bkt || dropped != e.drop) begin
						fails++;
						if (fails <= 10)
							$display("%0t mismatch exp kind=%0d id=%0d vis=%0b bkt=%0d drop=%0b got kind=%0d id=%0d vis=%0b bkt=%0d drop=%0b",
								$realtime, e.kind, e.id, e.vis, e.bkt, e.drop, result_kind,
								out_face_id, visible, bucket, dropped);
					end
					if (e.kind == KIND_FACE)
						faces_drained++;
					if (e.kind == KIND_DONE)
						drains_done++;
				end
			end
			if (push && !full) begin
				if (command)
					drain_next();
				else
					cull_and_bin();
			end
		end
	end

endmodule

FILE: dv/tb.sv
// Testbench top for the backface cull and depth bucket sort block: makes submit and
// drain traffic with random gaps and stalls and gives the verdict.
// Depends on bcds_pkg, the block and bcds_checker.
`timescale 1ns / 1ps

module tb import bcds_pkg::*;;

	localparam int ITEMS = 1950;
	localparam int LIMIT = 20000000;

	logic                      clk, arst_n, push, full, command, empty, pop;
	logic [ID_W-1:0]           face_id;
	logic signed [COORD_W-1:0] ax, ay, az, bx_coord, by_coord, bz_coord;
	logic signed [COORD_W-1:0] cx_coord, cy_coord, cz_coord;
	logic [1:0]                result_kind;
	logic [ID_W-1:0]           out_face_id;
	logic                      visible, dropped;
	logic [OUT_BKT_W-1:0]      bucket;
	int                        fails, pending, results_seen;
	int                        faces_drained, faces_dropped, faces_culled, drains_done;
	int                        sent, send_gap_max, cycles;
	bit                        held_off;

	backface_cull_depth_bucket_sort i_dut (.*);
	bcds_checker i_checker (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// hold the item on the ports until it is taken, then wait out a gap
	task automatic offer();
		int gap;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_face(input logic [ID_W-1:0] id,
			input int xa, ya, za, xb, yb, zb, xc, yc, zc);
		command <= 1'b0;
		face_id <= id;
		ax <= COORD_W'(xa); ay <= COORD_W'(ya); az <= COORD_W'(za);
		bx_coord <= COORD_W'(xb); by_coord <= COORD_W'(yb); bz_coord <= COORD_W'(zb);
		cx_coord <= COORD_W'(xc); cy_coord <= COORD_W'(yc); cz_coord <= COORD_W'(zc);
		offer();
	endtask

	// a=(0,0,za) b=(0,1,zb) c=(1,0,zc): visible exactly when za > 0
	task automatic put_depths(input logic [ID_W-1:0] id, input int za, zb, zc);
		put_face(id, 0, 0, za, 0, 1, zb, 1, 0, zc);
	endtask

	task automatic put_drain();
		command <= 1'b1;
		face_id <= 10'($urandom);
		offer();
	endtask

	task automatic run_frame();
		int n, base, step, mid;
		n = $urandom_range(1, 30);
		base = $urandom_range(0, 1023);
		step = 2 * $urandom_range(0, 511) + 1;
		mid = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 6) == 0)
				put_face(10'(base + i * step), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom);
			else
				put_face(10'(base + i * step), $urandom, $urandom,
					$urandom_range(0, 1700000), $urandom, $urandom,
					$urandom_range(0, 1700000), $urandom, $urandom,
					$urandom_range(0, ($urandom_range(0, 9) == 0) ? 8388607 : 1700000));
			if (i == n / 2)
				repeat (mid) put_drain();
		end
		// enough drains to finish the current scan and one full scan after it
		repeat (n + 2) put_drain();
	endtask

	initial begin
		int w;
		pop = 1'b1;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 14);
			if ((results_seen / 64) % 3 == 0)
				w = 0;
			if (!held_off && results_seen >= 200) begin
				held_off = 1'b1;
				w = 400;
			end
			if (w > 0) begin
				pop <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		push = 1'b0;
		command = 1'b0;
		face_id = '0;
		{ax, ay, az, bx_coord, by_coord, bz_coord, cx_coord, cy_coord, cz_coord} = '0;
		cycles = 0;
		sent = 0;
		send_gap_max = 14;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty sort, depth clamp, top bucket, out of range depth, culled and degenerate
		put_drain();
		put_depths(0, 1, -8388608, 0);
		put_depths(1023, 1, 5241599, 0);
		put_depths(5, 1, 5242879, 0);
		put_depths(6, -5, 100, 100);
		put_face(7, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607);
		put_face(8, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
			-8388608, -8388608, -8388608);
		put_face(12, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
			8388607, 8388607, -8388608);
		put_face(9, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		put_depths(2, 1, 12800, 0);
		put_depths(3, 1, 12800, 0);
		put_drain();
		put_drain();
		// submit into the bucket being drained, and into a higher one
		put_depths(4, 1, 12800, 0);
		put_depths(11, 1, 128000, 0);
		repeat (8) put_drain();

		while (sent < ITEMS - 10)
			run_frame();

		// repeated id in one frame links the face to itself
		send_gap_max = 3;
		put_depths(20, 1, 2560, 0);
		put_depths(20, 1, 2560, 0);
		repeat (6) put_drain();
		push <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		$display("%0d items in, %0d results out: %0d faces drained, %0d culled, %0d dropped",
			sent, results_seen, faces_drained, faces_culled, faces_dropped);
		$display("%0d drains finished, %0d result mismatches", drains_done, fails);
		if (fails == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/bcds_pkg.sv
rtl/core/bcds_fifo.sv
rtl/core/bcds_front.sv
rtl/core/bcds_back.sv
rtl/core/backface_cull_depth_bucket_sort.sv
dv/bcds_checker.sv
dv/tb.sv
